// ===== rtl/core/polar_vector_unit_assert.svh =====
// Assertion macros shared by the checker of the polar vector unit.
// Depends on nothing; included by the checker file.
`ifndef POLAR_VECTOR_UNIT_ASSERT_SVH
`define POLAR_VECTOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PVU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/pvu_pkg.sv =====
// Package for the polar vector unit: widths, modes, arctangent table, defaults.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pvu_pkg;
  localparam int CordicStepsDef = 24;
  localparam int FracBitsDef    = 16;
  localparam int IW = 36;
  localparam int AW = 33;
  localparam longint GainQ30 = 652032874;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  typedef enum logic [2:0] {
    MODE_TO_POLAR = 3'd0, MODE_FROM_POLAR = 3'd1, MODE_SET_LENGTH = 3'd2,
    MODE_SET_ANGLE = 3'd3, MODE_ROTATE = 3'd4, MODE_ADD_LENGTH = 3'd5,
    MODE_SCALE = 3'd6, MODE_SPARE = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] len;
    logic signed [31:0] ang;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic [30:0]        length_out;
    logic signed [31:0] angle_out;
    logic               length_less;
    logic               length_equal;
    logic               saturated;
  } result_t;

  function automatic logic [31:0] atan_unit(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
      3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
      9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
      15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
      21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
      24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
      27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
      30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pvu_if.sv =====
// Valid/ready channel interface for the polar vector unit.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface pvu_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pvu_stage.sv =====
// One CORDIC iteration register stage, vectoring or rotating.
// Depends on pvu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvu_stage #(
  parameter int STEP = 0
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic                            vectoring,
  input  wire logic signed [pvu_pkg::IW-1:0]   x_i,
  input  wire logic signed [pvu_pkg::IW-1:0]   y_i,
  input  wire logic signed [pvu_pkg::AW-1:0]   z_i,
  output logic signed [pvu_pkg::IW-1:0]        x_r,
  output logic signed [pvu_pkg::IW-1:0]        y_r,
  output logic signed [pvu_pkg::AW-1:0]        z_r
);
  localparam logic signed [pvu_pkg::AW-1:0] Atan =
    pvu_pkg::AW'(pvu_pkg::atan_unit(STEP));
  logic dir_pos;
  logic signed [pvu_pkg::IW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [pvu_pkg::AW-1:0] z_nxt;
  always_comb begin
    dx = x_i >>> STEP;
    dy = y_i >>> STEP;
    // rotate toward y=0 when vectoring, toward z=0 when rotating
    dir_pos = vectoring ? !y_i[pvu_pkg::IW-1] : !z_i[pvu_pkg::AW-1];
    if (vectoring ^ dir_pos) begin
      x_nxt = x_i + dy; y_nxt = y_i - dx;
    end else begin
      x_nxt = x_i - dy; y_nxt = y_i + dx;
    end
    if (vectoring) z_nxt = dir_pos ? z_i + Atan : z_i - Atan;
    else           z_nxt = dir_pos ? z_i - Atan : z_i + Atan;
    if (vectoring && dir_pos) begin
      x_nxt = x_i + dy; y_nxt = y_i - dx;
    end else if (vectoring) begin
      x_nxt = x_i - dy; y_nxt = y_i + dx;
    end else if (dir_pos) begin
      x_nxt = x_i - dy; y_nxt = y_i + dx;
    end else begin
      x_nxt = x_i + dy; y_nxt = y_i - dx;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/polar_vector_unit.sv =====
// Top level of the polar vector unit: two CORDIC pipelines with gain removal.
// Depends on pvu_pkg, pvu_if and pvu_stage.
`timescale 1ns / 1ps
`default_nettype none
// Polar vector unit. Takes one vector beat per cycle unless the output stalls,
// and returns one result beat per input beat, in order. The pipe has
// 2*CORDIC_STEPS + 5 register stages: a prerotate stage, the vectoring CORDIC
// chain, a gain multiply stage, operand select, the rotating CORDIC chain, a
// second gain multiply stage and the output register. Every stage holds a valid
// bit; the whole pipe advances when the output register is empty or taken, so
// a stall holds everything in place and drops nothing. Input ready is low during
// reset. Mode 0 gives length and angle and compares length with the len field
// of the input beat; modes 1-5 rebuild a vector from polar operands; mode 6
// multiplies by a Q factor with FRAC_BITS fraction bits. Mode 7 behaves like
// mode 0. Outputs saturate and set the saturated flag.
module polar_vector_unit #(
  parameter int CORDIC_STEPS = pvu_pkg::CordicStepsDef,
  parameter int FRAC_BITS    = pvu_pkg::FracBitsDef
) (
  input wire logic clk,
  input wire logic rst_n,
  pvu_if.sink      in_ch,
  pvu_if.source    out_ch
);
  localparam int IW = pvu_pkg::IW;
  localparam int AW = pvu_pkg::AW;
  localparam int NV = CORDIC_STEPS;
  // stages: 0 prerotate, 1..NV vectoring, NV+1 gain, NV+2 select/prerotate,
  // NV+3..2NV+2 rotating, 2NV+3 gain mult, 2NV+4 saturate/output
  localparam int NS = 2 * NV + 5;

  logic adv;
  logic [NS-1:0] v_r;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = rst_n && adv;

  // item carried alongside the chains
  pvu_pkg::item_t it_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_ch.valid};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= in_ch.data;
      for (int k = 1; k < NS; k++) it_r[k] <= it_r[k-1];
    end
  end

  // ---- vectoring prerotate ----
  logic signed [IW-1:0] vx [NV+1];
  logic signed [IW-1:0] vy [NV+1];
  logic signed [AW-1:0] vz [NV+1];
  logic signed [IW-1:0] vx0_r, vy0_r;
  logic signed [AW-1:0] vz0_r;
  logic zero0_r;
  logic signed [IW-1:0] px, py;
  logic signed [AW-1:0] pz;
  always_comb begin
    px = IW'(in_ch.data.x); py = IW'(in_ch.data.y); pz = '0;
    if (in_ch.data.x < 0) begin
      if (in_ch.data.y >= 0) begin
        px = IW'(in_ch.data.y); py = -IW'(in_ch.data.x); pz = AW'(pvu_pkg::QuarterTurn);
      end else begin
        px = -IW'(in_ch.data.y); py = IW'(in_ch.data.x); pz = -AW'(pvu_pkg::QuarterTurn);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vx0_r <= px; vy0_r <= py; vz0_r <= pz;
      zero0_r <= (in_ch.data.x == 0) && (in_ch.data.y == 0);
    end
  end
  assign vx[0] = vx0_r;
  assign vy[0] = vy0_r;
  assign vz[0] = vz0_r;
  logic [NS-1:0] zero_r;
  always_ff @(posedge clk) begin
    if (adv) zero_r <= {zero_r[NS-2:0], zero0_r};
  end

  for (genvar i = 0; i < NV; i++) begin : g_vec
    pvu_stage #(.STEP(i)) u_st (
      .clk(clk), .en(adv), .vectoring(1'b1),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_r(vx[i+1]), .y_r(vy[i+1]), .z_r(vz[i+1])
    );
  end

  // ---- gain removal on length ----
  logic signed [AW:0] mag_r;   // 34-bit signed length
  logic [31:0] ang_r;
  logic signed [IW+31:0] mprod;
  assign mprod = vx[NV] * (IW+32)'(pvu_pkg::GainQ30) + (IW+32)'(64'sd1 <<< 29);
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= zero_r[NV-1] ? '0 : (AW+1)'(mprod >>> 30);
      ang_r <= zero_r[NV-1] ? '0 : vz[NV][31:0];
    end
  end
  localparam int SG = NV + 1;  // stage index whose item matches mag_r

  // ---- operand select and rotate prerotate ----
  pvu_pkg::item_t si;
  assign si = it_r[SG];
  logic signed [IW-1:0] sel_len;
  logic signed [31:0] sel_ang;
  logic signed [IW-1:0] rx0, ry0;
  logic signed [AW-1:0] rz0;
  always_comb begin
    case (pvu_pkg::mode_t'(si.mode))
      pvu_pkg::MODE_FROM_POLAR: begin sel_len = IW'(si.len); sel_ang = si.ang; end
      pvu_pkg::MODE_SET_LENGTH: begin sel_len = IW'(si.len); sel_ang = ang_r; end
      pvu_pkg::MODE_SET_ANGLE:  begin sel_len = IW'(mag_r); sel_ang = si.ang; end
      pvu_pkg::MODE_ROTATE:     begin sel_len = IW'(mag_r); sel_ang = ang_r + si.ang; end
      pvu_pkg::MODE_ADD_LENGTH: begin sel_len = IW'(mag_r) + IW'(si.len); sel_ang = ang_r; end
      default:                  begin sel_len = '0; sel_ang = '0; end
    endcase
    rx0 = sel_len; ry0 = '0; rz0 = AW'(sel_ang);
    if (sel_ang >= $signed(pvu_pkg::QuarterTurn)) begin
      rx0 = '0; ry0 = sel_len; rz0 = AW'(sel_ang) - AW'(pvu_pkg::QuarterTurn);
    end else if (sel_ang < -$signed({1'b0, pvu_pkg::QuarterTurn})) begin
      rx0 = '0; ry0 = -sel_len; rz0 = AW'(sel_ang) + AW'(pvu_pkg::QuarterTurn);
    end
  end
  logic signed [IW-1:0] rx [NV+1];
  logic signed [IW-1:0] ry [NV+1];
  logic signed [AW-1:0] rz [NV+1];
  logic signed [IW-1:0] rx0_r, ry0_r;
  logic signed [AW-1:0] rz0_r;
  logic signed [AW:0] magp_r [NV+2];
  logic [31:0] angp_r [NV+2];
  always_ff @(posedge clk) begin
    if (adv) begin
      rx0_r <= rx0; ry0_r <= ry0; rz0_r <= rz0;
      magp_r[0] <= mag_r; angp_r[0] <= ang_r;
      for (int k = 1; k < NV + 2; k++) begin
        magp_r[k] <= magp_r[k-1]; angp_r[k] <= angp_r[k-1];
      end
    end
  end
  assign rx[0] = rx0_r;
  assign ry[0] = ry0_r;
  assign rz[0] = rz0_r;
  for (genvar i = 0; i < NV; i++) begin : g_rot
    pvu_stage #(.STEP(i)) u_st (
      .clk(clk), .en(adv), .vectoring(1'b0),
      .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
      .x_r(rx[i+1]), .y_r(ry[i+1]), .z_r(rz[i+1])
    );
  end

  // ---- gain removal / scale products ----
  localparam int SM = 2 * NV + 2;
  pvu_pkg::item_t mi;
  assign mi = it_r[SM];
  logic scl;
  assign scl = (mi.mode == pvu_pkg::MODE_SCALE);
  logic signed [IW+31:0] ma_x, ma_y, mb_x, mb_y;
  logic signed [IW+31:0] px_r, py_r;
  always_comb begin
    ma_x = scl ? (IW+32)'(mi.x) : (IW+32)'(rx[NV]);
    ma_y = scl ? (IW+32)'(mi.y) : (IW+32)'(ry[NV]);
    mb_x = scl ? (IW+32)'(mi.len) : (IW+32)'(pvu_pkg::GainQ30);
    mb_y = mb_x;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= ma_x * mb_x;
      py_r <= ma_y * mb_y;
    end
  end

  // ---- round, saturate, output register ----
  localparam int SO = SM + 1;
  pvu_pkg::item_t oi;
  assign oi = it_r[SO];
  logic signed [IW+31:0] rnd, fx, fy;
  logic signed [AW:0] mg;
  logic [31:0] ag;
  pvu_pkg::result_t res;
  logic sat;
  always_comb begin
    mg = magp_r[NV+1];
    ag = angp_r[NV+1];
    sat = 1'b0;
    res = '0;
    if (oi.mode == pvu_pkg::MODE_SCALE) begin
      rnd = (IW+32)'(64'sd1 <<< (FRAC_BITS - 1));
      fx = (px_r + rnd) >>> FRAC_BITS;
      fy = (py_r + rnd) >>> FRAC_BITS;
    end else begin
      rnd = (IW+32)'(64'sd1 <<< 29);
      fx = (px_r + rnd) >>> 30;
      fy = (py_r + rnd) >>> 30;
    end
    if (oi.mode == pvu_pkg::MODE_TO_POLAR || oi.mode == pvu_pkg::MODE_SPARE) begin
      fx = (IW+32)'(oi.x);
      fy = (IW+32)'(oi.y);
      res.length_less  = mg < (AW+1)'(oi.len);
      res.length_equal = mg == (AW+1)'(oi.len);
    end
    if (mg > (AW+1)'(32'sh7FFF_FFFF)) begin
      res.length_out = 31'h7FFF_FFFF; sat = 1'b1;
    end else res.length_out = mg[30:0];
    if (fx > (IW+32)'(32'sh7FFF_FFFF)) begin res.x_out = 32'sh7FFF_FFFF; sat = 1'b1; end
    else if (fx < -(IW+32)'(33'sh0_8000_0000)) begin
      res.x_out = 32'sh8000_0000; sat = 1'b1;
    end else res.x_out = fx[31:0];
    if (fy > (IW+32)'(32'sh7FFF_FFFF)) begin res.y_out = 32'sh7FFF_FFFF; sat = 1'b1; end
    else if (fy < -(IW+32)'(33'sh0_8000_0000)) begin
      res.y_out = 32'sh8000_0000; sat = 1'b1;
    end else res.y_out = fy[31:0];
    res.angle_out = ag;
    res.saturated = sat;
  end
  always_ff @(posedge clk) begin
    if (adv) out_ch.data <= res;
  end
  assign out_ch.valid = v_r[NS-1];

  // unused tail bits of carried data are dropped here
  logic unused_ok;
  assign unused_ok = ^{zero_r[NS-1:NV], vy[NV], vz[NV][AW-1], rz[NV], mprod,
                       si, mi, oi, it_r[NS-1]};
endmodule
`default_nettype wire

// ===== rtl/core/pvu_checker.sv =====
// Port-level checker for the polar vector unit, bound to the top level.
// Depends on polar_vector_unit_assert.svh and pvu_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_vector_unit_assert.svh"
module pvu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pvu_pkg::result_t out_data
);
  `PVU_ASSERT_IMPL(a_ready_follows_out, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `PVU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed under stall")
  `PVU_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(out_data.length_less && out_data.length_equal), "less and equal both set")
endmodule
bind polar_vector_unit pvu_checker u_pvu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
